### sv/periodic_budget_tick_accounting_top_macros.svh
// Assertion macros shared by the checker.
`ifndef PERIODIC_BUDGET_TICK_ACCOUNTING_TOP_MACROS_SVH
`define PERIODIC_BUDGET_TICK_ACCOUNTING_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBTA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pbta_pkg.sv
package pbta_pkg;

    localparam int SLOT_BITS = 4;
    localparam int SLOTS = 16;
    localparam int BUDGET_W = 16;
    localparam int TOTAL_W = 32;
    localparam int TICK_W = 32;
    localparam int MASK_W = 15;

    localparam logic [SLOT_BITS-1:0] IDLE_THREAD = 4'd14;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = 4'd15;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef struct packed {
        logic [BUDGET_W-1:0] budget;
        logic [BUDGET_W-1:0] period;
        logic                enable;
    } cfg_entry_t;

    typedef struct packed {
        logic is_cur;
        logic is_idle;
        logic counted;
    } slot_ctl_t;

endpackage

### sv/pbta_cfg_mem.sv
module pbta_cfg_mem (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [pbta_pkg::SLOT_BITS-1:0]     wr_addr,
    input  pbta_pkg::cfg_entry_t               wr_data,
    input  logic                               rd_en,
    input  logic [pbta_pkg::SLOT_BITS-1:0]     rd_addr,
    output pbta_pkg::cfg_entry_t               rd_data
);

    pbta_pkg::cfg_entry_t mem [pbta_pkg::SLOTS];
    logic [pbta_pkg::SLOTS-1:0] written_reg;
    pbta_pkg::cfg_entry_t rd_word_reg;
    logic rd_live_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_live_reg <= written_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as its reset value of zero.
    assign rd_data = rd_live_reg ? rd_word_reg : '0;

endmodule

### sv/pbta_cnt_mem.sv
module pbta_cnt_mem #(
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [pbta_pkg::SLOT_BITS-1:0]     wr_addr,
    input  logic [COUNT_BITS-1:0]              wr_run,
    input  logic [COUNT_BITS-1:0]              wr_elapsed,
    input  logic [pbta_pkg::TOTAL_W-1:0]       wr_total,
    input  logic                               rd_en,
    input  logic [pbta_pkg::SLOT_BITS-1:0]     rd_addr,
    output logic [COUNT_BITS-1:0]              rd_run,
    output logic [COUNT_BITS-1:0]              rd_elapsed,
    output logic [pbta_pkg::TOTAL_W-1:0]       rd_total
);

    localparam int WORD_W = 2 * COUNT_BITS + pbta_pkg::TOTAL_W;

    logic [WORD_W-1:0] mem [pbta_pkg::SLOTS];
    logic [pbta_pkg::SLOTS-1:0] written_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic [WORD_W-1:0] rd_word;
    logic rd_live_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_run, wr_elapsed, wr_total};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_live_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_live_reg ? rd_word_reg : '0;
    assign rd_run = rd_word[WORD_W-1 -: COUNT_BITS];
    assign rd_elapsed = rd_word[pbta_pkg::TOTAL_W +: COUNT_BITS];
    assign rd_total = rd_word[pbta_pkg::TOTAL_W-1:0];

endmodule

### sv/pbta_slot_alu.sv
module pbta_slot_alu #(
    parameter int COUNT_BITS = 16
) (
    input  pbta_pkg::slot_ctl_t                ctl,
    input  pbta_pkg::cfg_entry_t               cfg,
    input  logic [COUNT_BITS-1:0]              run_in,
    input  logic [COUNT_BITS-1:0]              elapsed_in,
    input  logic [pbta_pkg::TOTAL_W-1:0]       total_in,
    input  logic                               runnable_in,
    output logic [COUNT_BITS-1:0]              run_out,
    output logic [COUNT_BITS-1:0]              elapsed_out,
    output logic [pbta_pkg::TOTAL_W-1:0]       total_out,
    output logic                               runnable_out,
    output logic                               exhausted
);

    localparam int CMP_W = (COUNT_BITS > pbta_pkg::BUDGET_W) ? COUNT_BITS : pbta_pkg::BUDGET_W;

    logic [COUNT_BITS-1:0] run_inc;
    logic [COUNT_BITS-1:0] elapsed_inc;

    always_comb
    begin
        run_inc = ctl.is_cur ? run_in + 1'b1 : run_in;
        total_out = ctl.is_cur ? total_in + 1'b1 : total_in;
        exhausted = ctl.is_cur && !ctl.is_idle
                    && (CMP_W'(run_inc) >= CMP_W'(cfg.budget));
        run_out = exhausted ? '0 : run_inc;
        runnable_out = ctl.is_cur ? !exhausted : runnable_in;
        elapsed_out = elapsed_in;
        elapsed_inc = elapsed_in + 1'b1;

        // Period release follows the current-thread update of the same tick.
        if (ctl.counted && cfg.enable)
        begin
            if (CMP_W'(elapsed_inc) >= CMP_W'(cfg.period))
            begin
                runnable_out = 1'b1;
                elapsed_out = '0;
                run_out = '0;
            end
            else
            begin
                elapsed_out = elapsed_inc;
            end
        end
    end

endmodule

### sv/periodic_budget_tick_accounting_top.sv
// A load beat is taken without stalling the input and returns no result.
// A tick beat walks all sixteen slot entries through the counter memory, one per cycle,
// then passes the LAST and DONE states; DONE holds while the output register is stalled.
// No new beat is taken until the walk is through and the result has been registered.
// Reset clears the tick counter, the runnable flags, the output valid flag and the written
// marks of both tables, so every entry reads as zero until it is written.
module periodic_budget_tick_accounting_top #(
    parameter int THREADS = 14,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [0:0]  operation,
    input  logic [3:0]  current_thread,
    input  logic [3:0]  entry_index,
    input  logic [15:0] entry_budget,
    input  logic [15:0] entry_period,
    input  logic        entry_enable,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] tick_count,
    output logic [14:0] runnable_mask,
    output logic        current_exhausted,
    output logic [31:0] current_total_time
);

    localparam logic [4:0] THREAD_LIM = 5'(THREADS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_LAST = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [pbta_pkg::SLOT_BITS-1:0] walk_addr_reg;
    logic [pbta_pkg::SLOT_BITS-1:0] proc_addr_reg;
    logic [pbta_pkg::SLOT_BITS-1:0] cur_reg;
    logic proc_vld_reg;
    logic [pbta_pkg::TICK_W-1:0] tick_count_reg;
    logic [pbta_pkg::SLOTS-1:0] runnable_reg;
    logic exh_cap_reg;
    logic [pbta_pkg::TOTAL_W-1:0] total_cap_reg;

    logic result_valid_reg;
    logic [pbta_pkg::TICK_W-1:0] res_tick_reg;
    logic [pbta_pkg::MASK_W-1:0] res_mask_reg;
    logic res_exh_reg;
    logic [pbta_pkg::TOTAL_W-1:0] res_total_reg;

    logic item_accept;
    logic tick_go;
    logic load_go;
    logic out_free;
    logic walk_rd;

    pbta_pkg::cfg_entry_t cfg_wr;
    pbta_pkg::cfg_entry_t cfg_rd;
    pbta_pkg::slot_ctl_t ctl;

    logic [COUNT_BITS-1:0] rd_run;
    logic [COUNT_BITS-1:0] rd_elapsed;
    logic [pbta_pkg::TOTAL_W-1:0] rd_total;
    logic [COUNT_BITS-1:0] new_run;
    logic [COUNT_BITS-1:0] new_elapsed;
    logic [pbta_pkg::TOTAL_W-1:0] new_total;
    logic new_runnable;
    logic new_exhausted;

    assign item_stall = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign tick_go = item_accept && (operation == pbta_pkg::OP_TICK);
    assign load_go = item_accept && (operation == pbta_pkg::OP_LOAD)
                     && ({1'b0, entry_index} < THREAD_LIM);
    assign out_free = !result_valid_reg || !result_stall;
    assign walk_rd = (state_reg == ST_WALK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_go)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_addr_reg == pbta_pkg::SLOT_LAST)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_wr = '{budget: entry_budget, period: entry_period, enable: entry_enable};

    pbta_cfg_mem u_cfg_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_go),
        .wr_addr (entry_index),
        .wr_data (cfg_wr),
        .rd_en   (walk_rd),
        .rd_addr (walk_addr_reg),
        .rd_data (cfg_rd)
    );

    pbta_cnt_mem #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cnt_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (proc_vld_reg),
        .wr_addr    (proc_addr_reg),
        .wr_run     (new_run),
        .wr_elapsed (new_elapsed),
        .wr_total   (new_total),
        .rd_en      (walk_rd),
        .rd_addr    (walk_addr_reg),
        .rd_run     (rd_run),
        .rd_elapsed (rd_elapsed),
        .rd_total   (rd_total)
    );

    assign ctl.is_cur = (proc_addr_reg == cur_reg);
    assign ctl.is_idle = (proc_addr_reg == pbta_pkg::IDLE_THREAD);
    assign ctl.counted = ({1'b0, proc_addr_reg} < THREAD_LIM);

    pbta_slot_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_slot_alu (
        .ctl          (ctl),
        .cfg          (cfg_rd),
        .run_in       (rd_run),
        .elapsed_in   (rd_elapsed),
        .total_in     (rd_total),
        .runnable_in  (runnable_reg[proc_addr_reg]),
        .run_out      (new_run),
        .elapsed_out  (new_elapsed),
        .total_out    (new_total),
        .runnable_out (new_runnable),
        .exhausted    (new_exhausted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_addr_reg <= '0;
            proc_vld_reg <= 1'b0;
            tick_count_reg <= '0;
            runnable_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            proc_vld_reg <= walk_rd;
            if (tick_go)
            begin
                walk_addr_reg <= '0;
                tick_count_reg <= tick_count_reg + 1'b1;
            end
            else if (walk_rd)
            begin
                walk_addr_reg <= walk_addr_reg + 1'b1;
            end
            if (proc_vld_reg)
            begin
                runnable_reg[proc_addr_reg] <= new_runnable;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_addr_reg <= walk_addr_reg;
        if (tick_go)
        begin
            cur_reg <= current_thread;
        end
        if (proc_vld_reg && ctl.is_cur)
        begin
            exh_cap_reg <= new_exhausted;
            total_cap_reg <= new_total;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            res_tick_reg <= tick_count_reg;
            res_mask_reg <= runnable_reg[pbta_pkg::MASK_W-1:0];
            res_exh_reg <= exh_cap_reg;
            res_total_reg <= total_cap_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign tick_count = res_tick_reg;
    assign runnable_mask = res_mask_reg;
    assign current_exhausted = res_exh_reg;
    assign current_total_time = res_total_reg;

endmodule

### sv/pbta_checker.sv
`include "periodic_budget_tick_accounting_top_macros.svh"

module pbta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic [0:0]  operation,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] tick_count
);

    `PBTA_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result beat dropped while stalled")
    `PBTA_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(tick_count), "stalled result beat changed")
    `PBTA_ASSERT_NEXT(a_tick_busy, item_valid && !item_stall && (operation == pbta_pkg::OP_TICK), item_stall, "tick beat did not start the slot walk")
    `PBTA_ASSERT_NEXT(a_load_quick, item_valid && !item_stall && (operation == pbta_pkg::OP_LOAD), !item_stall, "load beat blocked the input")
    `PBTA_ASSERT_SAME(a_result_after_walk, $rose(result_valid), $past(item_stall), "result appeared without a slot walk")

endmodule

bind periodic_budget_tick_accounting_top pbta_checker u_pbta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .tick_count   (tick_count)
);
